### rtl/crtt_pkg.sv
// ----------------------------------------------------------------------------
// crtt_pkg
// Shared types, constants and weight functions of the trail tessellator.
// ----------------------------------------------------------------------------
package crtt_pkg;

   localparam int NUM_SAMPLES = 4;
   localparam int NUM_COORDS  = 6;
   localparam int CNT_W       = 4;   // interp_count and step index width
   localparam int WGT_W       = 15;  // signed spline weight width
   localparam int DEN_W       = 13;  // 2*n^3 for n up to 15
   localparam int ACC_EXT     = 15;  // accumulator growth over coordinate width

   localparam logic [CNT_W-1:0] INTERP_COUNT_RESET = 4'd4;
   localparam logic             CSR_INTERP_COUNT   = 1'b0;

   typedef struct packed {
      logic       shift;
      logic       wgt_load;
      logic       mac_en;
      logic       mac_first;
      logic [1:0] mac_sel;
      logic       div_load;
      logic       div_step;
      logic       res_load;
   } cmd_type;

   // integer spline weight of sample s (0 = newest) at step j of n
   function automatic logic signed [WGT_W-1:0] calc_weight(
      input logic [CNT_W-1:0] j, input logic [CNT_W-1:0] n, input logic [1:0] s);
      int jj;
      int nn;
      int j2;
      int j3;
      int w;
      jj = int'(j);
      nn = int'(n);
      j2 = jj * jj;
      j3 = j2 * jj;
      case (s)
         2'd0: w = -j3 + 2 * j2 * nn - jj * nn * nn;
         2'd1: w = 3 * j3 - 5 * j2 * nn + 2 * nn * nn * nn;
         2'd2: w = -3 * j3 + 4 * j2 * nn + jj * nn * nn;
         default: w = j3 - j2 * nn;
      endcase
      return WGT_W'(w);
   endfunction

   function automatic logic [DEN_W-1:0] calc_den(input logic [CNT_W-1:0] n);
      int nn;
      nn = int'(n);
      return DEN_W'(2 * nn * nn * nn);
   endfunction

endpackage

### rtl/crtt_ctrl.sv
// ----------------------------------------------------------------------------
// crtt_ctrl
// Sequencer: history fill, step loop, multiply-accumulate and divide phases.
// ----------------------------------------------------------------------------
module crtt_ctrl #(
   parameter int COORD_BITS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [crtt_pkg::CNT_W-1:0]     interp_count,
   output logic [crtt_pkg::CNT_W-1:0]     step_index,
   output logic                           last_of_run,
   output crtt_pkg::cmd_type              cmd
);

   localparam int DCNT_W = $clog2(COORD_BITS);

   typedef enum logic [2:0] {
      IDLE, WGT, MAC, PREP, DIV, RES, OUT
   } state_type;

   state_type                  state_ff, state_in;
   logic [2:0]                 fill_ff, fill_in;
   logic [crtt_pkg::CNT_W-1:0] step_ff, step_in;
   logic [1:0]                 sel_ff, sel_in;
   logic [DCNT_W-1:0]          dcnt_ff, dcnt_in;
   logic                       accept;
   logic                       last;

   assign accept      = req_valid && req_ready;
   assign last        = (step_ff == interp_count);
   assign req_ready   = (state_ff == IDLE);
   assign rsp_valid   = (state_ff == OUT);
   assign step_index  = step_ff;
   assign last_of_run = last;

   always_comb begin
      state_in = state_ff;
      fill_in  = fill_ff;
      step_in  = step_ff;
      sel_in   = sel_ff;
      dcnt_in  = dcnt_ff;
      cmd      = '0;
      cmd.mac_sel   = sel_ff;
      cmd.mac_first = (sel_ff == 2'd0);
      case (state_ff)
         IDLE: begin
            if (accept) begin
               cmd.shift = 1'b1;
               if (fill_ff != 3'(crtt_pkg::NUM_SAMPLES)) fill_in = fill_ff + 3'd1;
               step_in = '0;
               if (fill_in == 3'(crtt_pkg::NUM_SAMPLES) && interp_count != '0)
                  state_in = WGT;
            end
         end
         WGT: begin
            cmd.wgt_load = 1'b1;
            sel_in       = 2'd0;
            state_in     = MAC;
         end
         MAC: begin
            cmd.mac_en = 1'b1;
            sel_in     = sel_ff + 2'd1;
            if (sel_ff == 2'd3) state_in = PREP;
         end
         PREP: begin
            cmd.div_load = 1'b1;
            dcnt_in      = '0;
            state_in     = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            dcnt_in      = dcnt_ff + DCNT_W'(1);
            if (dcnt_ff == DCNT_W'(COORD_BITS - 1)) state_in = RES;
         end
         RES: begin
            cmd.res_load = 1'b1;
            state_in     = OUT;
         end
         OUT: begin
            if (rsp_ready) begin
               if (last) begin
                  state_in = IDLE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = WGT;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         fill_ff  <= '0;
         step_ff  <= '0;
         sel_ff   <= '0;
         dcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         step_ff  <= step_in;
         sel_ff   <= sel_in;
         dcnt_ff  <= dcnt_in;
      end
   end

endmodule

### rtl/crtt_dpath.sv
// ----------------------------------------------------------------------------
// crtt_dpath
// Sample history, weight registers, per-coordinate multiply-accumulate,
// bit-serial rounding divider and saturating result registers.
// ----------------------------------------------------------------------------
module crtt_dpath #(
   parameter int COORD_BITS = 32
) (
   input  logic                              clock,
   input  crtt_pkg::cmd_type                 cmd,
   input  logic [crtt_pkg::CNT_W-1:0]        step_index,
   input  logic [crtt_pkg::CNT_W-1:0]        interp_count,
   input  logic signed [COORD_BITS-1:0]      in_coord [crtt_pkg::NUM_COORDS],
   output logic signed [COORD_BITS-1:0]      out_coord [crtt_pkg::NUM_COORDS]
);

   localparam int ACC_W = COORD_BITS + crtt_pkg::ACC_EXT;
   localparam int PRD_W = COORD_BITS + crtt_pkg::WGT_W;
   localparam int DEN_W = crtt_pkg::DEN_W;
   localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   logic signed [COORD_BITS-1:0]     hist_ff [crtt_pkg::NUM_SAMPLES][crtt_pkg::NUM_COORDS];
   logic signed [crtt_pkg::WGT_W-1:0] wgt_ff [crtt_pkg::NUM_SAMPLES];
   logic [DEN_W-1:0]                 den_ff;

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         for (int c = 0; c < crtt_pkg::NUM_COORDS; c++) begin
            hist_ff[0][c] <= in_coord[c];
            for (int s = 1; s < crtt_pkg::NUM_SAMPLES; s++) hist_ff[s][c] <= hist_ff[s-1][c];
         end
      end
      if (cmd.wgt_load) begin
         for (int s = 0; s < crtt_pkg::NUM_SAMPLES; s++)
            wgt_ff[s] <= crtt_pkg::calc_weight(step_index, interp_count, 2'(s));
         den_ff <= crtt_pkg::calc_den(interp_count);
      end
   end

   for (genvar c = 0; c < crtt_pkg::NUM_COORDS; c++) begin : g_lane
      logic signed [PRD_W-1:0]      prod;
      logic signed [ACC_W-1:0]      acc_ff, acc_in;
      logic [ACC_W-1:0]             mag;
      logic [ACC_W-COORD_BITS-1:0]  upper;
      logic                         neg_ff, ovf_ff;
      logic [DEN_W-1:0]             rem_ff;
      logic [COORD_BITS-1:0]        quo_ff;
      logic [DEN_W:0]               rem2;
      logic [COORD_BITS-1:0]        negq;
      logic signed [COORD_BITS-1:0] res_in;
      logic signed [COORD_BITS-1:0] res_ff;

      assign prod   = wgt_ff[cmd.mac_sel] * hist_ff[cmd.mac_sel][c];
      assign acc_in = (cmd.mac_first ? ACC_W'(0) : acc_ff) + ACC_W'(prod);

      // magnitude plus half divisor gives round half away from zero
      assign mag   = (acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : ACC_W'(acc_ff))
                   + ACC_W'(den_ff >> 1);
      assign upper = mag[ACC_W-1:COORD_BITS];
      assign rem2  = {rem_ff, quo_ff[COORD_BITS-1]};
      assign negq  = -quo_ff;

      always_comb begin
         if (ovf_ff) begin
            res_in = neg_ff ? SAT_MIN : SAT_MAX;
         end else if (!neg_ff) begin
            res_in = quo_ff[COORD_BITS-1] ? SAT_MAX : quo_ff;
         end else begin
            res_in = (quo_ff > {1'b1, {(COORD_BITS-1){1'b0}}}) ? SAT_MIN : negq;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.mac_en) acc_ff <= acc_in;
         if (cmd.div_load) begin
            neg_ff <= acc_ff[ACC_W-1];
            ovf_ff <= (upper >= (ACC_W-COORD_BITS)'(den_ff));
            rem_ff <= DEN_W'(upper);
            quo_ff <= mag[COORD_BITS-1:0];
         end else if (cmd.div_step) begin
            // low dividend bits shift out as quotient bits shift in
            if (rem2 >= {1'b0, den_ff}) begin
               rem_ff <= DEN_W'(rem2 - {1'b0, den_ff});
               quo_ff <= {quo_ff[COORD_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= DEN_W'(rem2);
               quo_ff <= {quo_ff[COORD_BITS-2:0], 1'b0};
            end
         end
         if (cmd.res_load) res_ff <= res_in;
      end

      assign out_coord[c] = res_ff;
   end

endmodule

### rtl/catmull_rom_trail_tessellator_unit.sv
// ----------------------------------------------------------------------------
// catmull_rom_trail_tessellator_unit
// Uniform Catmull-Rom tessellator over the last four trail samples.
// ----------------------------------------------------------------------------
// points: each point passes the weight, multiply-accumulate, divide and
// result states, most of it in the bit-serial divider, and is held while
// rsp_ready is low; a new item is taken only after the last point of a run
// is taken, or one per cycle while fewer than four samples are held
// reset: history empty, interp_count 4, both channels idle
// ----------------------------------------------------------------------------
module catmull_rom_trail_tessellator_unit #(
   parameter int COORD_BITS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [COORD_BITS-1:0] req_start_x,
   input  logic signed [COORD_BITS-1:0] req_start_y,
   input  logic signed [COORD_BITS-1:0] req_start_z,
   input  logic signed [COORD_BITS-1:0] req_end_x,
   input  logic signed [COORD_BITS-1:0] req_end_y,
   input  logic signed [COORD_BITS-1:0] req_end_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_curve_start_x,
   output logic signed [COORD_BITS-1:0] rsp_curve_start_y,
   output logic signed [COORD_BITS-1:0] rsp_curve_start_z,
   output logic signed [COORD_BITS-1:0] rsp_curve_end_x,
   output logic signed [COORD_BITS-1:0] rsp_curve_end_y,
   output logic signed [COORD_BITS-1:0] rsp_curve_end_z,
   output logic [3:0]                   rsp_step_index,
   output logic                         rsp_last_of_run,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [2:0]                   csr_paddr,
   input  logic [31:0]                  csr_pwdata,
   output logic [31:0]                  csr_prdata,
   output logic                         csr_pready
);

   logic [crtt_pkg::CNT_W-1:0]   interp_count_ff;
   crtt_pkg::cmd_type            cmd;
   logic signed [COORD_BITS-1:0] in_coord  [crtt_pkg::NUM_COORDS];
   logic signed [COORD_BITS-1:0] out_coord [crtt_pkg::NUM_COORDS];
   logic                         csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready
                    && (csr_paddr[2] == crtt_pkg::CSR_INTERP_COUNT);
   assign csr_prdata = (csr_paddr[2] == crtt_pkg::CSR_INTERP_COUNT)
                    ? {28'd0, interp_count_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         interp_count_ff <= crtt_pkg::INTERP_COUNT_RESET;
      end else if (csr_wr) begin
         interp_count_ff <= csr_pwdata[3:0];
      end
   end

   assign in_coord[0] = req_start_x;
   assign in_coord[1] = req_start_y;
   assign in_coord[2] = req_start_z;
   assign in_coord[3] = req_end_x;
   assign in_coord[4] = req_end_y;
   assign in_coord[5] = req_end_z;

   crtt_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .interp_count (interp_count_ff),
      .step_index   (rsp_step_index),
      .last_of_run  (rsp_last_of_run),
      .cmd          (cmd)
   );

   crtt_dpath #(.COORD_BITS(COORD_BITS)) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .step_index   (rsp_step_index),
      .interp_count (interp_count_ff),
      .in_coord     (in_coord),
      .out_coord    (out_coord)
   );

   assign rsp_curve_start_x = out_coord[0];
   assign rsp_curve_start_y = out_coord[1];
   assign rsp_curve_start_z = out_coord[2];
   assign rsp_curve_end_x   = out_coord[3];
   assign rsp_curve_end_y   = out_coord[4];
   assign rsp_curve_end_z   = out_coord[5];

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("input taken while a point is pending");

   a_last_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_run |-> rsp_step_index == interp_count_ff)
      else $error("last flag on wrong step");

   a_no_early_point: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("point before computation");

endmodule
